[hdl/cave_pkg.sv]
// Shared constants, payload types and state encoding for the cave automaton.
package cave_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int DIM_W     = 7;                       // size registers and sweep counters
  localparam int COL_IW    = $clog2(MAX_WIDTH);
  localparam int ROW_AW    = $clog2(MAX_HEIGHT);
  localparam int REACH     = 2;
  localparam int WIN_ROWS  = 2 * REACH + 1;
  localparam int FILL_ROWS = 2 * REACH;
  localparam int PAD_W     = MAX_WIDTH + 2 * REACH;
  localparam int PAD_IW    = $clog2(PAD_W);
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [2:0] REG_NEAR   = 3'd0;
  localparam logic [2:0] REG_FAR    = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_REPS   = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] col;
    logic [5:0] row;
    logic       is_wall;
  } item_t;

  typedef struct packed {
    logic cell_wall;
    logic done_res;
    logic bad_coord;
  } result_t;

  typedef struct packed {
    logic [3:0] near_cutoff;
    logic [4:0] far_cutoff;
    logic [6:0] grid_width;
    logic [6:0] grid_height;
    logic [3:0] repetitions;
  } cfg_t;

  typedef logic [WIN_ROWS-1:0][MAX_WIDTH-1:0] win_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_WB,
    ST_GEN_START,
    ST_FILL,
    ST_SHIFT,
    ST_SWEEP,
    ST_ROW_WR,
    ST_RESP
  } state_t;

endpackage

[hdl/cave_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module cave_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/cave_eval.sv]
// Neighborhood evaluator: next value of one cell from a five-row window.
module cave_eval (
  input  cave_pkg::win_t                   win,
  input  logic [cave_pkg::DIM_W-1:0]       col,
  input  logic [cave_pkg::DIM_W-1:0]       used_width,
  input  cave_pkg::cfg_t                   cfg,
  output logic                             wall
);

  logic [cave_pkg::MAX_WIDTH-1:0]                     width_mask;
  logic [cave_pkg::WIN_ROWS-1:0][cave_pkg::PAD_W-1:0] padded;
  logic [cave_pkg::WIN_ROWS-1:0][4:0]                 slice;
  logic [3:0]                                         near_cnt;
  logic [4:0]                                         far_cnt;

  // Mask columns beyond the width in use: they count as floor.
  always_comb begin
    for (int i = 0; i < cave_pkg::MAX_WIDTH; i++) begin
      width_mask[i] = (cave_pkg::DIM_W'(i) < used_width);
    end
  end

  always_comb begin
    for (int k = 0; k < cave_pkg::WIN_ROWS; k++) begin
      padded[k] = {2'b00, win[k] & width_mask, 2'b00};
      slice[k]  = padded[k][cave_pkg::PAD_IW'(col) +: 5];
    end
  end

  // Count walls: inner 3x3 and the cornerless 5x5.
  always_comb begin
    near_cnt = '0;
    far_cnt  = '0;
    for (int k = 1; k <= 3; k++) begin
      for (int j = 1; j <= 3; j++) begin
        near_cnt = near_cnt + 4'(slice[k][j]);
      end
      for (int j = 0; j < 5; j++) begin
        far_cnt = far_cnt + 5'(slice[k][j]);
      end
    end
    for (int j = 1; j <= 3; j++) begin
      far_cnt = far_cnt + 5'(slice[0][j]) + 5'(slice[4][j]);
    end
  end

  assign wall = (near_cnt >= cfg.near_cutoff) || (far_cnt <= cfg.far_cutoff);

endmodule

[hdl/cave_cellular_automaton.sv]
// Top level of the cave cellular automaton: control, row window and register port.
//
// The grid lives in one row-wide RAM (one 64-bit row per entry). A load item is a
// read-modify-write of one row and a read item reads one row, each through ST_CELL_RD
// and ST_CELL_WB to a registered result in ST_RESP (a coordinate outside the grid skips
// ST_CELL_WB, an unknown kind goes straight to ST_RESP). A run item sweeps the interior
// one cell per cycle within a row through a single neighborhood evaluator fed from a
// five-row window of registers. Each generation fills the window in ST_FILL, then
// sweeps each interior row in ST_SWEEP and writes it back in ST_ROW_WR; a run does as
// many generations as the repetitions register holds. The window holds the old
// values of the rows around the current one, so each finished row is written back
// in place while the row three ahead is fetched, and the update stays simultaneous.
// Cells come out of reset undefined; every cell inside the grid must be loaded before
// a run or a read touches it. There is no clearing pass. Configuration registers sit
// on an APB port at byte addresses 0, 4, 8, 12 and 16 and may only be written while
// no item is in flight. A new item is taken while a finished result still waits.
module cave_cellular_automaton (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  cave_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output cave_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cave_pkg::ADDR_W-1:0]   paddr,
  input  logic [cave_pkg::DATA_W-1:0]   pwdata,
  output logic [cave_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  cave_pkg::state_t state, state_next;
  cave_pkg::cfg_t   cfg;
  cave_pkg::item_t  cur;
  cave_pkg::win_t   win;
  cave_pkg::result_t result_next;

  logic [cave_pkg::DIM_W-1:0]     used_w, used_h;
  logic [cave_pkg::DIM_W-1:0]     row_cnt, col_cnt;
  logic [cave_pkg::DIM_W:0]       ahead_row;
  logic [1:0]                     fill_cnt;
  logic [3:0]                     gens_left;
  logic [cave_pkg::MAX_WIDTH-1:0] new_bits;
  logic [cave_pkg::MAX_WIDTH-1:0] merged_row;
  logic [cave_pkg::MAX_WIDTH-1:0] cell_sel;
  logic                           read_bit;
  logic                           shift_pend, shift_zero;
  logic                           shift_pend_next, shift_zero_next;
  logic                           eval_wall;
  logic                           accept, cfg_write, bad, no_interior, out_free;
  logic [2:0]                     reg_idx;

  logic                           ram_we, ram_re;
  logic [cave_pkg::ROW_AW-1:0]    ram_waddr, ram_raddr;
  logic [cave_pkg::MAX_WIDTH-1:0] ram_wdata, ram_rdata;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_cutoff <= 4'd5;
      cfg.far_cutoff  <= 5'd2;
      cfg.grid_width  <= 7'd64;
      cfg.grid_height <= 7'd64;
      cfg.repetitions <= 4'd1;
    end else if (cfg_write) begin
      case (reg_idx)
        cave_pkg::REG_NEAR:   cfg.near_cutoff <= pwdata[3:0];
        cave_pkg::REG_FAR:    cfg.far_cutoff  <= pwdata[4:0];
        cave_pkg::REG_WIDTH:  cfg.grid_width  <= pwdata[6:0];
        cave_pkg::REG_HEIGHT: cfg.grid_height <= pwdata[6:0];
        cave_pkg::REG_REPS:   cfg.repetitions <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cave_pkg::REG_NEAR:   prdata = cave_pkg::DATA_W'(cfg.near_cutoff);
      cave_pkg::REG_FAR:    prdata = cave_pkg::DATA_W'(cfg.far_cutoff);
      cave_pkg::REG_WIDTH:  prdata = cave_pkg::DATA_W'(cfg.grid_width);
      cave_pkg::REG_HEIGHT: prdata = cave_pkg::DATA_W'(cfg.grid_height);
      cave_pkg::REG_REPS:   prdata = cave_pkg::DATA_W'(cfg.repetitions);
      default:              prdata = '0;
    endcase
  end

  // Clamp the size in use to the storage.
  assign used_w = (cfg.grid_width > cave_pkg::DIM_W'(cave_pkg::MAX_WIDTH)) ?
                  cave_pkg::DIM_W'(cave_pkg::MAX_WIDTH) : cfg.grid_width;
  assign used_h = (cfg.grid_height > cave_pkg::DIM_W'(cave_pkg::MAX_HEIGHT)) ?
                  cave_pkg::DIM_W'(cave_pkg::MAX_HEIGHT) : cfg.grid_height;

  assign no_interior = (used_w < cave_pkg::DIM_W'(3)) || (used_h < cave_pkg::DIM_W'(3));
  assign bad = (cave_pkg::DIM_W'(cur.col) >= used_w) || (cave_pkg::DIM_W'(cur.row) >= used_h);
  assign ahead_row = {1'b0, row_cnt} + (cave_pkg::DIM_W + 1)'(3);

  assign item_stall = (state != cave_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign cell_sel   = cave_pkg::MAX_WIDTH'(1) << cur.col;

  // Border bits of the row keep their old value; interior takes the new bits.
  always_comb begin
    for (int i = 0; i < cave_pkg::MAX_WIDTH; i++) begin
      merged_row[i] = ((i >= 1) && (cave_pkg::DIM_W'(i) <= used_w - cave_pkg::DIM_W'(2))) ?
                      new_bits[i] : win[2][i];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cave_pkg::ST_IDLE: begin
        if (accept) begin
          if (item.kind == cave_pkg::KIND_RUN) begin
            state_next = cave_pkg::ST_GEN_START;
          end else if (item.kind == cave_pkg::KIND_LOAD || item.kind == cave_pkg::KIND_READ) begin
            state_next = cave_pkg::ST_CELL_RD;
          end else begin
            state_next = cave_pkg::ST_RESP;
          end
        end
      end
      cave_pkg::ST_CELL_RD: begin
        state_next = bad ? cave_pkg::ST_RESP : cave_pkg::ST_CELL_WB;
      end
      cave_pkg::ST_CELL_WB: state_next = cave_pkg::ST_RESP;
      cave_pkg::ST_GEN_START: begin
        if (gens_left == 4'd0 || no_interior) begin
          state_next = cave_pkg::ST_RESP;
        end else begin
          state_next = cave_pkg::ST_FILL;
        end
      end
      cave_pkg::ST_FILL: begin
        if (fill_cnt == 2'(cave_pkg::FILL_ROWS - 1)) begin
          state_next = cave_pkg::ST_SHIFT;
        end
      end
      cave_pkg::ST_SHIFT: state_next = cave_pkg::ST_SWEEP;
      cave_pkg::ST_SWEEP: begin
        if (col_cnt == used_w - cave_pkg::DIM_W'(2)) begin
          state_next = cave_pkg::ST_ROW_WR;
        end
      end
      cave_pkg::ST_ROW_WR: begin
        if (row_cnt == used_h - cave_pkg::DIM_W'(2)) begin
          state_next = cave_pkg::ST_GEN_START;
        end else begin
          state_next = cave_pkg::ST_SHIFT;
        end
      end
      cave_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = cave_pkg::ST_IDLE;
        end
      end
      default: state_next = cave_pkg::ST_IDLE;
    endcase
  end

  // Memory strobes, window fetch control and the result word.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = cave_pkg::ROW_AW'(cur.row);
    ram_wdata       = merged_row;
    ram_re          = 1'b0;
    ram_raddr       = cave_pkg::ROW_AW'(cur.row);
    shift_pend_next = 1'b0;
    shift_zero_next = 1'b0;
    result_next     = '0;
    case (state)
      cave_pkg::ST_CELL_RD: begin
        ram_re = !bad;
      end
      cave_pkg::ST_CELL_WB: begin
        ram_we    = (cur.kind == cave_pkg::KIND_LOAD);
        ram_wdata = (ram_rdata & ~cell_sel) | (cur.is_wall ? cell_sel : '0);
      end
      cave_pkg::ST_FILL: begin
        ram_raddr       = cave_pkg::ROW_AW'(fill_cnt);
        ram_re          = (cave_pkg::DIM_W'(fill_cnt) < used_h);
        shift_pend_next = 1'b1;
        shift_zero_next = !(cave_pkg::DIM_W'(fill_cnt) < used_h);
      end
      cave_pkg::ST_ROW_WR: begin
        ram_we          = 1'b1;
        ram_waddr       = cave_pkg::ROW_AW'(row_cnt);
        ram_raddr       = cave_pkg::ROW_AW'(ahead_row);
        ram_re          = (ahead_row < {1'b0, used_h});
        shift_pend_next = 1'b1;
        shift_zero_next = !(ahead_row < {1'b0, used_h});
      end
      cave_pkg::ST_RESP: begin
        if (cur.kind == cave_pkg::KIND_RUN) begin
          result_next.done_res = 1'b1;
        end else if (cur.kind == cave_pkg::KIND_LOAD || cur.kind == cave_pkg::KIND_READ) begin
          result_next.bad_coord = bad;
          result_next.done_res  = !bad;
          result_next.cell_wall = !bad && (cur.kind == cave_pkg::KIND_READ) && read_bit;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cave_pkg::ST_IDLE;
      result_valid <= 1'b0;
      shift_pend   <= 1'b0;
    end else begin
      state      <= state_next;
      shift_pend <= shift_pend_next;
      if (state == cave_pkg::ST_RESP && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    shift_zero <= shift_zero_next;
    if (accept) begin
      cur       <= item;
      gens_left <= cfg.repetitions;
    end
    if (state == cave_pkg::ST_RESP && out_free) begin
      result <= result_next;
    end
    if (state == cave_pkg::ST_CELL_WB) begin
      read_bit <= ram_rdata[cave_pkg::COL_IW'(cur.col)];
    end
    // Start a generation with an empty window, first row of the interior.
    if (state == cave_pkg::ST_GEN_START) begin
      win       <= '0;
      fill_cnt  <= '0;
      row_cnt   <= cave_pkg::DIM_W'(1);
      gens_left <= gens_left - 4'd1;
    end else if (shift_pend) begin
      for (int k = 0; k < cave_pkg::WIN_ROWS - 1; k++) begin
        win[k] <= win[k + 1];
      end
      win[cave_pkg::WIN_ROWS - 1] <= shift_zero ? '0 : ram_rdata;
    end
    if (state == cave_pkg::ST_FILL) begin
      fill_cnt <= fill_cnt + 2'd1;
    end
    if (state == cave_pkg::ST_SHIFT) begin
      col_cnt <= cave_pkg::DIM_W'(1);
    end
    if (state == cave_pkg::ST_SWEEP) begin
      new_bits[cave_pkg::COL_IW'(col_cnt)] <= eval_wall;
      col_cnt <= col_cnt + cave_pkg::DIM_W'(1);
    end
    if (state == cave_pkg::ST_ROW_WR) begin
      row_cnt <= row_cnt + cave_pkg::DIM_W'(1);
    end
  end

  cave_eval u_eval (
    .win        (win),
    .col        (col_cnt),
    .used_width (used_w),
    .cfg        (cfg),
    .wall       (eval_wall)
  );

  cave_ram #(
    .WIDTH (cave_pkg::MAX_WIDTH),
    .DEPTH (cave_pkg::MAX_HEIGHT)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
